### rtl/weighted_pixel_accumulator_assert.svh
// Assertion macros for the weighted pixel accumulator.
`ifndef WEIGHTED_PIXEL_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_PIXEL_ACCUMULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define WPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define WPA_ASSERT(lbl, prop, msg)
`define WPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/wpa_pkg.sv
// Shared constants, types and helpers of the weighted pixel accumulator.
package wpa_pkg;
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_LAYERS = 2;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT * MAX_LAYERS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COLOR_W    = 16;
    localparam int WT_W       = 16;
    localparam int PROD_W     = COLOR_W + WT_W + 1;
    localparam int SUM_W      = 40;
    localparam int WSUM_W     = 32;
    localparam int OUT_W      = 24;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_SPLAT   = 3'd1;
    localparam logic [2:0] REQ_RESOLVE = 3'd2;
    localparam logic [2:0] REQ_SET     = 3'd3;
    localparam logic [2:0] REQ_FIX     = 3'd4;
    localparam logic [2:0] REQ_CLEAR   = 3'd5;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LAYERS = 2'd2;
    localparam logic [1:0] CFG_CUR    = 2'd3;

    localparam logic [WSUM_W-1:0] WEIGHT_ONE = WSUM_W'(256);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ADDR1, S_ADDR2, S_READ, S_CALC, S_DIV, S_FIN,
        S_SW_RD, S_SW_WR, S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        LOP_NONE, LOP_CLEAR, LOP_ACC, LOP_DIV_LOAD, LOP_DIV_STEP, LOP_FINISH
    } t_lane_op;

    typedef struct packed {
        t_lane_op          op;
        logic [ADDR_W-1:0] addr;
        logic              w_neg;
    } t_lane_ctrl;

    function automatic logic [7:0] eff_size(logic [7:0] v, logic [7:0] hi);
        logic [7:0] r;
        if (v == 8'd0) begin
            r = 8'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction
endpackage

### rtl/wpa_in_if.sv
// Request channel of the weighted pixel accumulator.
interface wpa_in_if import wpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               req_type;
    logic [6:0]               pixel_x;
    logic [6:0]               pixel_y;
    logic [13:0]              pixel_index;
    logic [COLOR_W-1:0]       red;
    logic [COLOR_W-1:0]       green;
    logic [COLOR_W-1:0]       blue;
    logic signed [WT_W-1:0]   weight;
    modport source(output valid, req_type, pixel_x, pixel_y, pixel_index, red, green, blue,
                   weight, input ready);
    modport sink(input valid, req_type, pixel_x, pixel_y, pixel_index, red, green, blue,
                 weight, output ready);
endinterface

### rtl/wpa_out_if.sv
// Result channel of the weighted pixel accumulator.
interface wpa_out_if import wpa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] resolved_red;
    logic signed [OUT_W-1:0] resolved_green;
    logic signed [OUT_W-1:0] resolved_blue;
    logic                    zero_weight;
    modport source(output valid, resolved_red, resolved_green, resolved_blue, zero_weight,
                   input ready);
    modport sink(input valid, resolved_red, resolved_green, resolved_blue, zero_weight,
                 output ready);
endinterface

### rtl/weighted_pixel_accumulator.sv
// Weighted pixel accumulator: per-pixel weighted color and weight sums with resolve.
// After reset the block sweeps its 32768-entry store to zero, one entry a cycle,
// before it takes the first request; configuration writes are taken during that pass.
// Add and splat inside the frame pass through two address states, read,
// multiply-accumulate, result and idle before the next transaction is accepted.
// Resolve runs the 40-step serial divider in each color lane; a zero weight skips
// the divider. A resolve outside the frame and an unknown request go from the
// address states straight to the result. Set weights and fix non-positive weights
// read and then write each pixel of the current layer's frame in turn, and clear
// each pixel over all layers in use. A result held by a stalled output keeps the
// block in its result state until the output register is free.
// Each request returns one result, held in an output register.
`include "weighted_pixel_accumulator_assert.svh"
module weighted_pixel_accumulator import wpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wpa_in_if.sink     i_in,
    wpa_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    t_state                 r_state;
    t_state                 n_state;
    logic [7:0]             r_cfg_fw;
    logic [7:0]             r_cfg_fh;
    logic [1:0]             r_cfg_layers;
    logic                   r_cfg_cur;

    logic [2:0]             r_req;
    logic [6:0]             r_px;
    logic [6:0]             r_py;
    logic [13:0]            r_pidx;
    logic [COLOR_W-1:0]     r_red;
    logic [COLOR_W-1:0]     r_green;
    logic [COLOR_W-1:0]     r_blue;
    logic signed [WT_W-1:0] r_w;

    logic [ADDR_W-1:0]      r_off;
    logic [ADDR_W-1:0]      r_area;
    logic                   r_in_frame;
    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W-1:0]      r_sw_addr;
    logic [CNT_W-1:0]       r_sw_left;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [WSUM_W-1:0]      r_wmag;
    logic                   r_use_q;
    logic                   r_zero;

    logic [WSUM_W-1:0]      r_wmem [DEPTH];
    logic [WSUM_W-1:0]      r_wrd;

    logic [7:0]             w_fw;
    logic [7:0]             w_fh;
    logic                   w_two_layers;
    logic                   w_cur;
    logic [ADDR_W-1:0]      w_base;
    logic [WSUM_W-1:0]      w_wext;
    logic [WSUM_W:0]        w_wsum;
    logic [WSUM_W-1:0]      w_wsat;
    logic                   w_accept;
    logic                   w_free;
    logic                   w_load;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [WSUM_W-1:0]      w_wdata;
    t_lane_ctrl             w_ctrl;
    logic [OUT_W-1:0]       w_res_r;
    logic [OUT_W-1:0]       w_res_g;
    logic [OUT_W-1:0]       w_res_b;

    assign w_accept = i_in.valid && i_in.ready;

    always_comb begin
        w_fw         = eff_size(r_cfg_fw, 8'(MAX_WIDTH));
        w_fh         = eff_size(r_cfg_fh, 8'(MAX_HEIGHT));
        w_two_layers = (r_cfg_layers >= 2'(MAX_LAYERS));
        w_cur        = w_two_layers && r_cfg_cur;
        w_base       = w_cur ? r_area : '0;
        w_wext       = WSUM_W'(r_w);
        w_wsum       = {r_wrd[WSUM_W-1], r_wrd} + (WSUM_W + 1)'(r_w);
        if (w_wsum[WSUM_W] != w_wsum[WSUM_W-1]) begin
            w_wsat = w_wsum[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                    : {1'b0, {(WSUM_W-1){1'b1}}};
        end else begin
            w_wsat = w_wsum[WSUM_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_sw_left == CNT_W'(1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid) n_state = S_ADDR1;
            end
            S_ADDR1: n_state = S_ADDR2;
            S_ADDR2: begin
                case (r_req)
                    REQ_ADD, REQ_SPLAT: n_state = r_in_frame ? S_READ : S_RESULT;
                    REQ_RESOLVE: n_state = (ADDR_W'(r_pidx) < r_area) ? S_READ : S_RESULT;
                    REQ_SET, REQ_FIX, REQ_CLEAR: n_state = S_SW_RD;
                    default: n_state = S_RESULT;
                endcase
            end
            S_READ: n_state = S_CALC;
            S_CALC: begin
                n_state = (r_req == REQ_RESOLVE && r_wrd != '0) ? S_DIV : S_RESULT;
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_FIN;
            end
            S_FIN: n_state = S_RESULT;
            S_SW_RD: n_state = S_SW_WR;
            S_SW_WR: n_state = (r_sw_left == CNT_W'(1)) ? S_RESULT : S_SW_RD;
            S_RESULT: begin
                if (w_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        w_ctrl.op    = LOP_NONE;
        w_ctrl.addr  = r_addr;
        // sign of the weight just read; the lanes take it at divider load
        w_ctrl.w_neg = r_wrd[WSUM_W-1];
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        i_in.ready   = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            S_INIT: begin
                w_ctrl.op   = LOP_CLEAR;
                w_ctrl.addr = r_sw_addr;
                w_we        = 1'b1;
                w_waddr     = r_sw_addr;
            end
            S_IDLE: i_in.ready = 1'b1;
            S_CALC: begin
                if (r_req == REQ_ADD || r_req == REQ_SPLAT) begin
                    w_ctrl.op = LOP_ACC;
                end else if (r_req == REQ_RESOLVE && r_wrd != '0) begin
                    w_ctrl.op = LOP_DIV_LOAD;
                end
                if (r_req == REQ_ADD) begin
                    w_we    = 1'b1;
                    w_wdata = w_wsat;
                end
            end
            S_DIV: w_ctrl.op = LOP_DIV_STEP;
            S_FIN: w_ctrl.op = LOP_FINISH;
            S_SW_RD: w_ctrl.addr = r_sw_addr;
            S_SW_WR: begin
                w_ctrl.addr = r_sw_addr;
                w_waddr     = r_sw_addr;
                case (r_req)
                    REQ_SET: begin
                        w_we    = 1'b1;
                        w_wdata = w_wext;
                    end
                    REQ_FIX: begin
                        // replace non-positive weights only
                        w_we    = r_wrd[WSUM_W-1] || (r_wrd == '0);
                        w_wdata = WEIGHT_ONE;
                    end
                    REQ_CLEAR: begin
                        w_ctrl.op = LOP_CLEAR;
                        w_we      = 1'b1;
                        w_wdata   = w_wext;
                    end
                    default: begin
                    end
                endcase
            end
            S_RESULT: w_load = w_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wrd <= r_wmem[w_ctrl.addr];
        if (w_we) r_wmem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_cfg_fw     <= 8'(MAX_WIDTH);
            r_cfg_fh     <= 8'(MAX_HEIGHT);
            r_cfg_layers <= 2'd1;
            r_cfg_cur    <= 1'b0;
            r_sw_addr    <= '0;
            r_sw_left    <= CNT_W'(DEPTH);
            r_cnt        <= '0;
            r_use_q      <= 1'b0;
            r_zero       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_fw     <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_fh     <= i_cfg_data;
                    CFG_LAYERS: r_cfg_layers <= i_cfg_data[1:0];
                    CFG_CUR:    r_cfg_cur    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_req   <= i_in.req_type;
                r_px    <= i_in.pixel_x;
                r_py    <= i_in.pixel_y;
                r_pidx  <= i_in.pixel_index;
                r_red   <= i_in.red;
                r_green <= i_in.green;
                r_blue  <= i_in.blue;
                r_w     <= i_in.weight;
                r_use_q <= 1'b0;
                r_zero  <= 1'b0;
            end
            case (r_state)
                S_INIT, S_SW_WR: begin
                    r_sw_addr <= r_sw_addr + 1'b1;
                    r_sw_left <= r_sw_left - 1'b1;
                end
                S_ADDR1: begin
                    r_off      <= (r_req == REQ_RESOLVE) ? ADDR_W'(r_pidx)
                                  : ADDR_W'(w_fw * r_py) + ADDR_W'(r_px);
                    r_area     <= ADDR_W'(w_fw * w_fh);
                    r_in_frame <= ({1'b0, r_px} < w_fw) && ({1'b0, r_py} < w_fh);
                end
                S_ADDR2: begin
                    r_addr    <= w_base + r_off;
                    r_sw_addr <= (r_req == REQ_CLEAR) ? '0 : w_base;
                    r_sw_left <= (r_req == REQ_CLEAR && w_two_layers) ? {r_area, 1'b0}
                                                                      : {1'b0, r_area};
                end
                S_CALC: begin
                    r_wmag <= r_wrd[WSUM_W-1] ? (~r_wrd + 1'b1) : r_wrd;
                    r_cnt  <= '0;
                    if (r_req == REQ_RESOLVE) begin
                        r_zero  <= (r_wrd == '0);
                        r_use_q <= (r_wrd != '0);
                    end
                end
                S_DIV: r_cnt <= r_cnt + 1'b1;
                default: begin
                end
            endcase
        end
    end

    wpa_lane u_lane_red (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_color(r_red), .i_weight(r_w),
        .i_wmag(r_wmag), .o_res(w_res_r)
    );
    wpa_lane u_lane_green (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_color(r_green), .i_weight(r_w),
        .i_wmag(r_wmag), .o_res(w_res_g)
    );
    wpa_lane u_lane_blue (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_color(r_blue), .i_weight(r_w),
        .i_wmag(r_wmag), .o_res(w_res_b)
    );

    wpa_merge u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load), .i_use_q(r_use_q),
        .i_zero(r_zero), .i_red(w_res_r), .i_green(w_res_g), .i_blue(w_res_b),
        .o_free(w_free), .o_out(o_out)
    );

    `WPA_ASSERT(a_accept_starts, w_accept |=> r_state == S_ADDR1, "accept did not start work")
    `WPA_ASSERT(a_load_free, w_load |-> (!o_out.valid || o_out.ready), "result overwritten")
    `WPA_ASSERT(a_div_bound, r_state == S_DIV |-> r_cnt < DIV_CNT_W'(DIV_STEPS), "divider overrun")
    `WPA_ASSERT(a_sweep_left, r_state == S_SW_WR |-> r_sw_left != '0, "sweep past its end")
    `WPA_ASSERT_ALWAYS(a_no_ready_busy, (r_state != S_IDLE) |-> !i_in.ready, "ready while busy")
endmodule

### rtl/wpa_lane.sv
// One color lane: sum memory, multiply-accumulate and serial divider.
module wpa_lane import wpa_pkg::*; (
    input  logic                  i_clk,
    input  t_lane_ctrl            i_ctrl,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic signed [WT_W-1:0] i_weight,
    input  logic [WSUM_W-1:0]     i_wmag,
    output logic [OUT_W-1:0]      o_res
);
    localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((64'd1 << (OUT_W - 1)) - 1);
    localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(64'd1 << (OUT_W - 1));
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic [SUM_W-1:0]          r_mem [DEPTH];
    logic [SUM_W-1:0]          r_rd;
    logic signed [PROD_W-1:0]  r_prod;
    logic [WSUM_W-1:0]         r_rem;
    logic [SUM_W-1:0]          r_quo;
    logic                      r_neg;
    logic [OUT_W-1:0]          r_res;

    logic [SUM_W:0]            w_sum;
    logic [SUM_W-1:0]          w_acc;
    logic [SUM_W-1:0]          w_mag;
    logic [WSUM_W:0]           w_sh;
    logic [WSUM_W:0]           w_diff;

    always_comb begin
        w_sum = {r_rd[SUM_W-1], r_rd} + (SUM_W + 1)'(r_prod);
        if (w_sum[SUM_W] != w_sum[SUM_W-1]) begin
            w_acc = w_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_acc = w_sum[SUM_W-1:0];
        end
        w_mag  = r_rd[SUM_W-1] ? (~r_rd + 1'b1) : r_rd;
        w_sh   = {r_rem, r_quo[SUM_W-1]};
        w_diff = w_sh - {1'b0, i_wmag};
    end

    always_ff @(posedge i_clk) begin
        r_rd   <= r_mem[i_ctrl.addr];
        r_prod <= $signed({1'b0, i_color}) * i_weight;
        case (i_ctrl.op)
            LOP_CLEAR: begin
                r_mem[i_ctrl.addr] <= '0;
            end
            LOP_ACC: begin
                r_mem[i_ctrl.addr] <= w_acc;
            end
            LOP_DIV_LOAD: begin
                r_quo <= w_mag;
                r_rem <= '0;
                r_neg <= r_rd[SUM_W-1] ^ i_ctrl.w_neg;
            end
            LOP_DIV_STEP: begin
                // restoring step: one quotient bit per cycle
                if (!w_diff[WSUM_W]) begin
                    r_rem <= w_diff[WSUM_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[WSUM_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
            end
            LOP_FINISH: begin
                if (!r_neg) begin
                    r_res <= (r_quo > POS_LIM) ? OUT_MAX : r_quo[OUT_W-1:0];
                end else begin
                    r_res <= (r_quo > NEG_LIM) ? OUT_MIN : (~r_quo[OUT_W-1:0] + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;
endmodule

### rtl/wpa_merge.sv
// Merge stage: combines lane quotients and flags into the result register.
module wpa_merge import wpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_use_q,
    input  logic             i_zero,
    input  logic [OUT_W-1:0] i_red,
    input  logic [OUT_W-1:0] i_green,
    input  logic [OUT_W-1:0] i_blue,
    output logic             o_free,
    wpa_out_if.source        o_out
);
    logic             r_valid;
    logic             n_valid;
    logic [OUT_W-1:0] r_red;
    logic [OUT_W-1:0] r_green;
    logic [OUT_W-1:0] r_blue;
    logic             r_zero;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            // zero unless the lanes carry a real quotient
            r_red   <= i_use_q ? i_red : '0;
            r_green <= i_use_q ? i_green : '0;
            r_blue  <= i_use_q ? i_blue : '0;
            r_zero  <= i_zero;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.resolved_red   = r_red;
    assign o_out.resolved_green = r_green;
    assign o_out.resolved_blue  = r_blue;
    assign o_out.zero_weight    = r_zero;
endmodule

### bench/weighted_pixel_accumulator_tb.sv
// Self-checking bench for the weighted pixel accumulator with a scoreboard of results.
module weighted_pixel_accumulator_tb;
    import wpa_pkg::*;

    typedef struct {
        logic [2:0]         req_type;
        logic [6:0]         pixel_x;
        logic [6:0]         pixel_y;
        logic [13:0]        pixel_index;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic signed [15:0] weight;
        bit                 drain;
    } t_request;

    typedef struct {
        logic signed [23:0] red;
        logic signed [23:0] green;
        logic signed [23:0] blue;
        logic               zero_weight;
    } t_pixel_out;

    localparam longint ACC_MAX = 64'sd549755813887;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint WACC_MAX = 64'sd2147483647;
    localparam longint WACC_MIN = -WACC_MAX - 1;
    localparam longint PIX_MAX = 64'sd8388607;
    localparam longint PIX_MIN = -PIX_MAX - 1;
    localparam int CYCLE_LIMIT = 3000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    wpa_in_if  in_if ();
    wpa_out_if out_if ();

    weighted_pixel_accumulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow of the film store and its registers
    longint red_acc [DEPTH];
    longint green_acc [DEPTH];
    longint blue_acc [DEPTH];
    longint weight_acc [DEPTH];
    logic [7:0] sh_width, sh_height;
    logic [1:0] sh_layers;
    logic       sh_cur;

    t_request   pending_q [$];
    t_pixel_out resolved_q [$];
    int         errors;
    int         sent;
    int         cycles;

    function automatic int clip_size(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [23:0] divide_channel(longint s, longint w);
        longint q;
        q = sat(s / w, PIX_MIN, PIX_MAX);
        return q[23:0];
    endfunction

    function automatic t_pixel_out accumulate(t_request r);
        t_pixel_out o;
        int fw, fh, nl, area, base, a, cl;
        longint w;
        fw = clip_size(sh_width, MAX_WIDTH);
        fh = clip_size(sh_height, MAX_HEIGHT);
        nl = clip_size(sh_layers, MAX_LAYERS);
        area = fw * fh;
        cl = (sh_cur < nl) ? sh_cur : nl - 1;
        base = cl * area;
        w = r.weight;
        o = '{default: 0};
        case (r.req_type)
            REQ_ADD, REQ_SPLAT: begin
                if (r.pixel_x < fw && r.pixel_y < fh) begin
                    a = base + fw * r.pixel_y + r.pixel_x;
                    if (a < DEPTH) begin
                        red_acc[a] = sat(red_acc[a] + longint'(r.red) * w, ACC_MIN, ACC_MAX);
                        green_acc[a] = sat(green_acc[a] + longint'(r.green) * w,
                                           ACC_MIN, ACC_MAX);
                        blue_acc[a] = sat(blue_acc[a] + longint'(r.blue) * w, ACC_MIN, ACC_MAX);
                        if (r.req_type == REQ_ADD)
                            weight_acc[a] = sat(weight_acc[a] + w, WACC_MIN, WACC_MAX);
                    end
                end
            end
            REQ_RESOLVE: begin
                if (r.pixel_index < area && base + r.pixel_index < DEPTH) begin
                    a = base + r.pixel_index;
                    if (weight_acc[a] == 0) begin
                        o.zero_weight = 1'b1;
                    end else begin
                        o.red = divide_channel(red_acc[a], weight_acc[a]);
                        o.green = divide_channel(green_acc[a], weight_acc[a]);
                        o.blue = divide_channel(blue_acc[a], weight_acc[a]);
                    end
                end
            end
            REQ_SET: begin
                for (int i = 0; i < area && base + i < DEPTH; i++) weight_acc[base + i] = w;
            end
            REQ_FIX: begin
                for (int i = 0; i < area && base + i < DEPTH; i++)
                    if (weight_acc[base + i] <= 0) weight_acc[base + i] = 256;
            end
            REQ_CLEAR: begin
                for (int i = 0; i < area * nl && i < DEPTH; i++) begin
                    red_acc[i] = 0;
                    green_acc[i] = 0;
                    blue_acc[i] = 0;
                    weight_acc[i] = w;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: one transaction per queued request, random gap between them
    t_request cur_req;
    int       send_gap;
    bit       send_calm;

    always @(posedge i_clk) begin
        automatic bit v = in_if.valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (v && in_if.ready) begin
                resolved_q.push_back(accumulate(cur_req));
                v = 0;
                sent++;
                if (sent % 150 == 0) send_calm = ~send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 6);
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].drain && resolved_q.size() != 0)) begin
                    cur_req = pending_q.pop_front();
                    in_if.req_type <= cur_req.req_type;
                    in_if.pixel_x <= cur_req.pixel_x;
                    in_if.pixel_y <= cur_req.pixel_y;
                    in_if.pixel_index <= cur_req.pixel_index;
                    in_if.red <= cur_req.red;
                    in_if.green <= cur_req.green;
                    in_if.blue <= cur_req.blue;
                    in_if.weight <= cur_req.weight;
                    v = 1;
                end
            end
            in_if.valid <= v;
        end
    end

    // Monitor: random back-pressure, compare each result with the oldest prediction
    int  recv_wait;
    int  received;
    bit  recv_calm;

    always @(posedge i_clk) begin
        automatic t_pixel_out e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                received++;
                if (received % 170 == 0) recv_calm = ~recv_calm;
                if (resolved_q.size() == 0) begin
                    $display("%0t: result with none expected: %h %h %h %b", $time,
                             out_if.resolved_red, out_if.resolved_green,
                             out_if.resolved_blue, out_if.zero_weight);
                    errors++;
                end else begin
                    e = resolved_q.pop_front();
                    if (out_if.resolved_red !== e.red || out_if.resolved_green !== e.green ||
                        out_if.resolved_blue !== e.blue ||
                        out_if.zero_weight !== e.zero_weight) begin
                        $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b",
                                 $time, e.red, e.green, e.blue, e.zero_weight,
                                 out_if.resolved_red, out_if.resolved_green,
                                 out_if.resolved_blue, out_if.zero_weight);
                        errors++;
                    end
                end
                recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
            end
            out_if.ready <= (recv_wait == 0);
            if (recv_wait > 0) recv_wait--;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_request mk(logic [2:0] op, int x, int y, int idx,
                                    int r, int g, int b, int w);
        t_request q;
        q.req_type = op;
        q.pixel_x = 7'(x);
        q.pixel_y = 7'(y);
        q.pixel_index = 14'(idx);
        q.red = 16'(r);
        q.green = 16'(g);
        q.blue = 16'(b);
        q.weight = 16'(w);
        q.drain = 0;
        return q;
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 4))
            0: return 16'hffff;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0001;
            4, 5: return 16'($urandom);
            6: return 16'(-$urandom_range(1, 512));
            default: return 16'($urandom_range(1, 512));
        endcase
    endfunction

    // Random request, aimed mostly at a few pixels near the origin so resolves see data
    function automatic t_request gen_request(bit whole_ok);
        t_request q;
        int fw, fh, hx, hy, k;
        fw = clip_size(sh_width, MAX_WIDTH);
        fh = clip_size(sh_height, MAX_HEIGHT);
        hx = (fw < 4) ? fw : 4;
        hy = (fh < 4) ? fh : 4;
        q = mk(REQ_ADD, 0, 0, 0, pick_color(), pick_color(), pick_color(), pick_weight());
        k = $urandom_range(0, 99);
        if (k < 38) q.req_type = REQ_ADD;
        else if (k < 52) q.req_type = REQ_SPLAT;
        else if (k < 88) q.req_type = REQ_RESOLVE;
        else if (k < 91) q.req_type = whole_ok ? REQ_SET : REQ_ADD;
        else if (k < 94) q.req_type = whole_ok ? REQ_FIX : REQ_SPLAT;
        else if (k < 96) q.req_type = whole_ok ? REQ_CLEAR : REQ_RESOLVE;
        else q.req_type = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) == 0) begin
            q.pixel_x = 7'($urandom);
            q.pixel_y = 7'($urandom);
        end else begin
            q.pixel_x = 7'($urandom_range(0, hx - 1));
            q.pixel_y = 7'($urandom_range(0, hy - 1));
        end
        if ($urandom_range(0, 9) == 0) q.pixel_index = 14'($urandom);
        else q.pixel_index = 14'(fw * $urandom_range(0, hy - 1) + $urandom_range(0, hx - 1));
        q.drain = ($urandom_range(0, 99) == 0);
        return q;
    endfunction

    task automatic wait_idle();
        wait (pending_q.size() == 0 && !in_if.valid && resolved_q.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(int w, int h, int l, int c);
        @(posedge i_clk);
        cfg_we <= 1'b1; cfg_index <= CFG_WIDTH; cfg_data <= 8'(w);
        @(posedge i_clk);
        cfg_index <= CFG_HEIGHT; cfg_data <= 8'(h);
        @(posedge i_clk);
        cfg_index <= CFG_LAYERS; cfg_data <= 8'(l);
        @(posedge i_clk);
        cfg_index <= CFG_CUR; cfg_data <= 8'(c);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sh_width = 8'(w);
        sh_height = 8'(h);
        sh_layers = 2'(l);
        sh_cur = 1'(c);
    endtask

    task automatic run_phase(int w, int h, int l, int c, int n);
        int area;
        write_regs(w, h, l, c);
        area = clip_size(w, MAX_WIDTH) * clip_size(h, MAX_HEIGHT) * clip_size(l, MAX_LAYERS);
        for (int i = 0; i < n; i++) pending_q.push_back(gen_request(area <= 1024));
        wait_idle();
    endtask

    initial begin
        errors = 0;
        sent = 0;
        received = 0;
        cycles = 0;
        send_calm = 0;
        recv_calm = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.req_type = '0;
        in_if.pixel_x = '0;
        in_if.pixel_y = '0;
        in_if.pixel_index = '0;
        in_if.red = '0;
        in_if.green = '0;
        in_if.blue = '0;
        in_if.weight = '0;
        out_if.ready = 1'b0;
        sh_width = 8'd128;
        sh_height = 8'd128;
        sh_layers = 2'd1;
        sh_cur = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            red_acc[i] = 0;
            green_acc[i] = 0;
            blue_acc[i] = 0;
            weight_acc[i] = 0;
        end
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full frame at reset settings
        pending_q.push_back(mk(REQ_ADD, 0, 0, 0, 'hffff, 'hffff, 'hffff, 'h7fff));
        pending_q.push_back(mk(REQ_ADD, 127, 127, 0, 0, 'h8000, 'h0001, 'h8000));
        pending_q.push_back(mk(REQ_SPLAT, 127, 127, 0, 'hffff, 0, 'hffff, 'h0100));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 16383, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 5, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 'h0001));
        pending_q.push_back(mk(REQ_SPLAT, 3, 2, 0, 'hffff, 'hffff, 'hffff, 'h7fff));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 259, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 'hff00));
        pending_q.push_back(mk(REQ_FIX, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 259, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(3'd6, 1, 1, 1, 'h1234, 'h5678, 'h9abc, 'h0100));
        pending_q.push_back(mk(3'd7, 1, 1, 1, 'h1234, 'h5678, 'h9abc, 'h0100));
        pending_q.push_back(mk(REQ_ADD, 1, 0, 0, 'h0100, 'h0200, 'h0300, 'h0080));
        pending_q.push_back(mk(REQ_RESOLVE, 0, 0, 1, 0, 0, 0, 0));
        wait_idle();

        run_phase(4, 3, 2, 1, 250);
        run_phase(0, 255, 0, 1, 200);
        run_phase(255, 1, 3, 0, 200);
        run_phase(1, 1, 1, 0, 200);
        run_phase(7, 5, 2, 0, 250);
        run_phase(2, 6, 2, 1, 150);
        // Largest frame, both layers: one clear, then pixel work only
        write_regs(128, 128, 2, 1);
        pending_q.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 'h0000));
        wait_idle();
        run_phase(128, 128, 2, 1, 200);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
